/* sv/tjfm_pkg.sv */
// ----------------------------------------------------------------------------
// Thruster jet failure monitor package
// Shared widths, register codes, reset values and the jet control and
// status structures.
// ----------------------------------------------------------------------------
package tjfm_pkg;

  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned TIME_W     = 20;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

  localparam logic [COUNT_W-1:0] PULSE_LIMIT_RST     = 4'd6;
  localparam logic [TIME_W-1:0]  FAIL_TIME_LIMIT_RST = 20'd80000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_LIMIT     = 1'b0,
    CFG_FAIL_TIME_LIMIT = 1'b1
  } cfg_idx_t;

  // Per-jet sample of one beat.
  typedef struct packed {
    logic                 rst;
    logic                 dem;
    logic                 chm;
    logic [ELAPSED_W-1:0] elapsed;
  } jet_cmd_t;

  // Per-jet status: registered count and limit checks on the next state.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               over_pulse;
    logic               over_time;
  } jet_stat_t;

endpackage

/* sv/tjfm_in_if.sv */
// ----------------------------------------------------------------------------
// Thruster jet failure monitor input channel
// Valid/ready channel carrying one tick of sampled jet signals.
// ----------------------------------------------------------------------------
interface tjfm_in_if
  import tjfm_pkg::*;
();

  logic                 valid;
  logic                 ready;
  logic                 reset_line;
  logic                 demand_a;
  logic                 demand_b;
  logic                 chamber_a;
  logic                 chamber_b;
  logic [ELAPSED_W-1:0] elapsed_us;

  modport source (
    output valid, reset_line, demand_a, demand_b, chamber_a, chamber_b, elapsed_us,
    input  ready
  );

  modport sink (
    input  valid, reset_line, demand_a, demand_b, chamber_a, chamber_b, elapsed_us,
    output ready
  );

endinterface

/* sv/tjfm_out_if.sv */
// ----------------------------------------------------------------------------
// Thruster jet failure monitor result channel
// Valid/ready channel carrying the failure latch and both pulse counts.
// ----------------------------------------------------------------------------
interface tjfm_out_if
  import tjfm_pkg::*;
();

  logic               valid;
  logic               ready;
  logic               failure;
  logic [COUNT_W-1:0] pulses_a;
  logic [COUNT_W-1:0] pulses_b;

  modport source (
    output valid, failure, pulses_a, pulses_b,
    input  ready
  );

  modport sink (
    input  valid, failure, pulses_a, pulses_b,
    output ready
  );

endinterface

/* sv/tjfm_jet.sv */
// ----------------------------------------------------------------------------
// Thruster jet failure monitor, single jet
// Pulse counter, pulse mark and saturating fail timer of one jet, updated
// once per enabled beat, with the limit checks on the updated state.
// ----------------------------------------------------------------------------
module tjfm_jet
  import tjfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  jet_cmd_t           cmd,
  input  logic [COUNT_W-1:0] pulse_limit,
  input  logic [TIME_W-1:0]  time_limit,
  output jet_stat_t          stat
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               mark_r, mark_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               mark_kept;
  logic [TIME_W:0]    time_sum;

  // Pulse counting: a new pulse needs the demand to drop first.
  always_comb begin
    mark_kept = mark_r & cmd.dem;
    count_nxt = count_r;
    mark_nxt  = mark_kept;
    if (cmd.rst || cmd.chm) begin
      count_nxt = '0;
      mark_nxt  = 1'b0;
    end else if (cmd.dem && !mark_kept) begin
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end
      mark_nxt = 1'b1;
    end
  end

  // Fail timer accumulates while demanded without chamber pressure.
  always_comb begin
    time_sum = {1'b0, time_r} + (TIME_W+1)'(cmd.elapsed);
    if (cmd.dem && !cmd.rst && !cmd.chm) begin
      time_nxt = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
    end else begin
      time_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mark_r  <= 1'b0;
      time_r  <= '0;
    end else if (en) begin
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
      time_r  <= time_nxt;
    end
  end

  // Status toward the failure latch.
  always_comb begin
    stat.count      = count_r;
    stat.over_pulse = (count_nxt >= pulse_limit);
    stat.over_time  = (time_nxt > time_limit);
  end

endmodule

/* sv/thruster_jet_failure_monitor_unit.sv */
// ----------------------------------------------------------------------------
// Thruster jet failure monitor
// Counts failed pulses and times demand without chamber pressure for two
// jets and keeps a sticky failure latch.
// ----------------------------------------------------------------------------
// The block takes one tick beat per clock cycle while the result side keeps
// up, and returns one result beat per tick: the beat passes the input
// register and then the result register, with the whole per-jet update (the
// timer add, saturation, count step, two compares) between them. While a
// finished result waits to be taken, the input register still takes one more
// beat and then holds the input off. The input ready follows the result ready
// in the same cycle, so a full rate stream runs without gaps. Configuration
// writes take effect at the next clock edge and are meant for idle periods.
module thruster_jet_failure_monitor_unit
  import tjfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tjfm_in_if.sink               in_ch,
  tjfm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COUNT_W-1:0]   pulse_limit_r;
  logic [TIME_W-1:0]    time_limit_r;

  logic                 s1_valid_r;
  logic                 s1_rst_r;
  logic                 s1_dem_a_r, s1_dem_b_r;
  logic                 s1_chm_a_r, s1_chm_b_r;
  logic [ELAPSED_W-1:0] s1_elapsed_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 latch_r, latch_nxt;
  logic                 adv;
  logic                 in_fire;
  jet_cmd_t             cmd_a, cmd_b;
  jet_stat_t            stat_a, stat_b;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_limit_r <= PULSE_LIMIT_RST;
      time_limit_r  <= FAIL_TIME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PULSE_LIMIT:     pulse_limit_r <= cfg_data[COUNT_W-1:0];
        CFG_FAIL_TIME_LIMIT: time_limit_r  <= cfg_data[TIME_W-1:0];
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result slot is free.
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rst_r     <= in_ch.reset_line;
      s1_dem_a_r   <= in_ch.demand_a;
      s1_dem_b_r   <= in_ch.demand_b;
      s1_chm_a_r   <= in_ch.chamber_a;
      s1_chm_b_r   <= in_ch.chamber_b;
      s1_elapsed_r <= in_ch.elapsed_us;
    end
  end

  // Per-jet update; the jet state doubles as the result register.
  assign cmd_a = '{rst: s1_rst_r, dem: s1_dem_a_r, chm: s1_chm_a_r, elapsed: s1_elapsed_r};
  assign cmd_b = '{rst: s1_rst_r, dem: s1_dem_b_r, chm: s1_chm_b_r, elapsed: s1_elapsed_r};

  tjfm_jet u_jet_a (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .cmd         (cmd_a),
    .pulse_limit (pulse_limit_r),
    .time_limit  (time_limit_r),
    .stat        (stat_a)
  );

  tjfm_jet u_jet_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .cmd         (cmd_b),
    .pulse_limit (pulse_limit_r),
    .time_limit  (time_limit_r),
    .stat        (stat_b)
  );

  // Sticky failure latch; reset wins over any limit.
  always_comb begin
    if (s1_rst_r) begin
      latch_nxt = 1'b0;
    end else begin
      latch_nxt = latch_r | stat_a.over_pulse | stat_b.over_pulse |
                  stat_a.over_time | stat_b.over_time;
    end
  end

  // Result valid: set by a new beat, cleared once taken.
  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      latch_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        latch_r <= latch_nxt;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.failure  = latch_r;
  assign out_ch.pulses_a = stat_a.count;
  assign out_ch.pulses_b = stat_b.count;

  // A beat with the reset line clears the latch and both counts.
  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_rst_r |=> !out_ch.failure && out_ch.pulses_a == '0 && out_ch.pulses_b == '0)
    else $error("reset beat did not clear latch and counts");

  // Without the reset line the latch never drops.
  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !s1_rst_r && latch_r |=> latch_r)
    else $error("failure latch dropped without reset");

  // Chamber pressure clears the first jet's count.
  a_chamber_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_chm_a_r |=> out_ch.pulses_a == '0)
    else $error("chamber pressure did not clear pulse count");

  // The second jet's count never drops unless reset or chamber pressure is seen.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !s1_rst_r && !s1_chm_b_r |=> out_ch.pulses_b >= $past(out_ch.pulses_b))
    else $error("pulse count decreased without clearing condition");

  // The result state moves only with a beat leaving the input register.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(latch_r) && $stable(stat_a.count) && $stable(stat_b.count))
    else $error("result state changed without a beat");

endmodule
